// File: src/swm_pkg.sv
package swm_pkg;

    localparam int SAMPLE_W       = 18;
    localparam int DATA_W         = 24;
    localparam int CFG_W          = 6;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;
    localparam int DEF_MAX_WINDOW = 32;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 6'd32;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic shift_en;
        logic load_probe;
        logic clear_rank;
        logic rank_en;
    } cell_ctrl_t;

endpackage

// File: src/swm_cell.sv
module swm_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 6,
    parameter int IDX_W = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  swm_pkg::sample_t   sample_in,
    input  swm_pkg::sample_t   probe_in,
    input  swm_pkg::sample_t   probe_bcast,
    input  logic [CNT_W-1:0]   step_k,
    output swm_pkg::sample_t   sample_out,
    output swm_pkg::sample_t   probe_out,
    output logic [IDX_W-1:0]   rank
);
    import swm_pkg::*;

    sample_t          sample_reg, sample_next;
    sample_t          probe_reg, probe_next;
    logic [IDX_W-1:0] rank_reg, rank_next;
    logic             hit;

    // probe ranks below this cell: smaller, or equal and newer position (lower index)
    assign hit = (probe_bcast < sample_reg)
              || ((probe_bcast == sample_reg) && (step_k < CNT_W'(INDEX)));

    always_comb
    begin
        sample_next = ctrl.shift_en ? sample_in : sample_reg;
        if (ctrl.load_probe)
        begin
            probe_next = sample_in;
        end
        else if (ctrl.rank_en)
        begin
            probe_next = probe_in;
        end
        else
        begin
            probe_next = probe_reg;
        end
        if (ctrl.clear_rank)
        begin
            rank_next = '0;
        end
        else if (ctrl.rank_en && hit)
        begin
            rank_next = rank_reg + IDX_W'(1);
        end
        else
        begin
            rank_next = rank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        probe_reg  <= probe_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    assign sample_out = sample_reg;
    assign probe_out  = probe_reg;
    assign rank       = rank_reg;

endmodule

// File: src/swm_avg.sv
module swm_avg (
    input  swm_pkg::sample_t a,
    input  swm_pkg::sample_t b,
    output swm_pkg::sample_t median
);
    import swm_pkg::*;

    logic signed [SAMPLE_W:0] sum;
    logic signed [SAMPLE_W:0] adj;

    // halve toward zero: bump negative sums by one before the shift
    assign sum    = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    assign adj    = sum + (SAMPLE_W+1)'(sum[SAMPLE_W]);
    assign median = adj[SAMPLE_W:1];

endmodule

// File: src/sliding_window_median.sv
// Item without tlast: shifted in; the next item can be taken the cycle after.
// Item with tlast: one rank pass per held sample runs along the cell chain
// (ST_RANK), the median pair is registered (ST_SEL), and the result is
// registered in ST_OUT once the output is free; next item taken after that.
// Reset (async, active low) clears fill count, step count, state, output valid
// and cell ranks, and sets window_length to 32; cell samples are not cleared.
module sliding_window_median #(
    parameter int MAX_WINDOW = swm_pkg::DEF_MAX_WINDOW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swm_pkg::APB_AW-1:0]  paddr,
    input  logic [swm_pkg::APB_DW-1:0]  pwdata,
    output logic [swm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [swm_pkg::DATA_W-1:0]  s_tdata,   // [17:0] sample
    input  logic                        s_tlast,   // end_of_round
    // output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [swm_pkg::DATA_W-1:0]  m_tdata    // [17:0] median
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RANK = 4'b0010,
        ST_SEL  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  wlen_reg, wlen_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              out_valid_reg, out_valid_next;
    sample_t           median_reg, median_next;
    sample_t           lo_reg, hi_reg;

    logic              cfg_wr;
    logic              accept_in;
    cell_ctrl_t        ctrl;
    logic [LEN_W-1:0]  len_ext, len_clip;
    logic [CNT_W-1:0]  eff_len, n_base, n_inc;
    logic [IDX_W-1:0]  hi_target, lo_target;
    sample_t           sel_lo, sel_hi, avg;

    sample_t           sample_w [MAX_WINDOW];
    sample_t           probe_w  [MAX_WINDOW];
    logic [IDX_W-1:0]  rank_w   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] lo_match, hi_match;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
    assign wlen_next = cfg_wr ? pwdata[CFG_W-1:0] : wlen_reg;
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH)
                  ? {{(APB_DW-CFG_W){1'b0}}, wlen_reg} : '0;

    // effective window length: zero reads as one, saturate at the cell count
    always_comb
    begin
        len_ext = LEN_W'(wlen_reg);
        if (len_ext == '0)
        begin
            len_clip = LEN_W'(1);
        end
        else if (len_ext > LEN_W'(MAX_WINDOW))
        begin
            len_clip = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len_clip = len_ext;
        end
        eff_len = CNT_W'(len_clip);
        n_base  = (fill_reg == CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW - 1) : fill_reg;
        n_inc   = n_base + CNT_W'(1);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;

    // cell chain, newest sample in cell 0
    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++)
        begin : g_cell
            sample_t sin, pin;
            if (g == 0)
            begin : g_head
                assign sin = s_tdata[SAMPLE_W-1:0];
            end
            else
            begin : g_body
                assign sin = sample_w[g-1];
            end
            if (g == MAX_WINDOW - 1)
            begin : g_tail
                assign pin = '0;
            end
            else
            begin : g_mid
                assign pin = probe_w[g+1];
            end

            swm_cell #(
                .INDEX (g),
                .CNT_W (CNT_W),
                .IDX_W (IDX_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .sample_in   (sin),
                .probe_in    (pin),
                .probe_bcast (probe_w[0]),
                .step_k      (k_reg),
                .sample_out  (sample_w[g]),
                .probe_out   (probe_w[g]),
                .rank        (rank_w[g])
            );

            assign hi_match[g] = (CNT_W'(g) < fill_reg) && (rank_w[g] == hi_target);
            assign lo_match[g] = (CNT_W'(g) < fill_reg) && (rank_w[g] == lo_target);
        end
    endgenerate

    assign hi_target = IDX_W'(fill_reg >> 1);
    assign lo_target = fill_reg[0] ? hi_target : (hi_target - IDX_W'(1));

    always_comb
    begin
        sel_lo = '0;
        sel_hi = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (lo_match[i])
            begin
                sel_lo = sel_lo | sample_w[i];
            end
            if (hi_match[i])
            begin
                sel_hi = sel_hi | sample_w[i];
            end
        end
    end

    swm_avg u_avg (
        .a      (lo_reg),
        .b      (hi_reg),
        .median (avg)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        median_next    = median_reg;
        out_valid_next = out_valid_reg;
        ctrl           = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    ctrl.shift_en = 1'b1;
                    fill_next     = (n_inc > eff_len) ? eff_len : n_inc;
                    if (s_tlast)
                    begin
                        ctrl.load_probe = 1'b1;
                        ctrl.clear_rank = 1'b1;
                        k_next          = '0;
                        state_next      = ST_RANK;
                    end
                end
            end
            ST_RANK:
            begin
                ctrl.rank_en = 1'b1;
                k_next       = k_reg + CNT_W'(1);
                if (k_reg == fill_reg - CNT_W'(1))
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    median_next    = avg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= WINDOW_LENGTH_RESET;
            fill_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wlen_reg      <= wlen_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
        if (state_reg == ST_SEL)
        begin
            lo_reg <= sel_lo;
            hi_reg <= sel_hi;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_W-SAMPLE_W){1'b0}}, median_reg};

    // ranks must form a permutation over the held samples
    a_hi_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL) |-> $onehot(hi_match))
        else $error("median upper pick not unique");

    a_lo_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL) |-> $onehot(lo_match))
        else $error("median lower pick not unique");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (fill_reg <= $past(eff_len)) && (fill_reg != '0))
        else $error("fill count outside window");

    a_round_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && s_tlast) |=> (state_reg == ST_RANK) && (k_reg == '0))
        else $error("rank pass did not start");

endmodule
